@@ hw/rtl/bspe_pkg.sv @@
// bicubic spline patch evaluator: shared types, codes and helpers
// used by bicubic_spline_patch_evaluator_unit and its testbench
// no dependencies
package bspe_pkg;

    localparam int MAX_U_SEGS_DEF = 16;
    localparam int MAX_V_SEGS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int              PARAM_BITS = 16;
    localparam logic [16:0]     PARAM_ONE  = 17'h10000;
    localparam int              TERMS      = 16;
    localparam int              COORDS     = 3;
    localparam int              SATW       = 72;
    localparam logic [1:0]      COORD_NONE = 2'd3;

    typedef enum logic [1:0] {
        REQ_WR_U    = 2'd0,
        REQ_WR_V    = 2'd1,
        REQ_WR_COEF = 2'd2,
        REQ_EVAL    = 2'd3
    } t_req_type;

    typedef enum logic {
        CFG_U_SEGS = 1'b0,
        CFG_V_SEGS = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RDN, S_SPAN, S_MUL, S_X, S_SRCH, S_OFF,
        S_P2M, S_P2W, S_P3M, S_P3W, S_MONO, S_ACC
    } t_state;

    typedef struct packed {
        t_req_type          req_type;
        logic [4:0]         break_index;
        logic [3:0]         patch_u;
        logic [3:0]         patch_v;
        logic [1:0]         coord_sel;
        logic [3:0]         term_index;
        logic signed [31:0] load_value;
        logic [16:0]        u_param;
        logic [16:0]        v_param;
    } t_req;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [3:0]         found_patch_u;
        logic [3:0]         found_patch_v;
        logic               overflow;
    } t_res;

    // clamp to signed 32 bits, msb of the result flags a clamp
    function automatic logic [32:0] sat32(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] smax;
        logic signed [SATW-1:0] smin;
        smax = SATW'(64'sd2147483647);
        smin = SATW'(-64'sd2147483648);
        if (v > smax) begin
            return {1'b1, 32'h7fff_ffff};
        end else if (v < smin) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

endpackage

@@ hw/rtl/bspe_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module bspe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/bicubic_spline_patch_evaluator_unit.sv @@
// bicubic spline patch evaluator, top level: sequencer around one shared multiplier
// depends on bspe_pkg and bspe_ram
//
//  channel   signals                               transaction at rising edge
//  request   i_start, o_busy, i_req                i_start && !o_busy
//  result    o_res_valid, o_res                    o_res_valid (one cycle strobe)
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data   valid && ready
//
// write requests finish in the cycle they are taken; busy stays low
// evaluate runs per axis the breakpoint reads, span, scaling multiply, breakpoint search and
//   offset powers, then the monomial and multiply-accumulate steps, all paced by the single
//   33x33 multiplier and the breakpoint/coefficient read ports
// synchronous active-low reset clears the sequencer; stores are undefined until written
// the receiver cannot stall: the result is shown for exactly one cycle
module bicubic_spline_patch_evaluator_unit
    import bspe_pkg::*;
#(
    parameter int MAX_U_SEGS = MAX_U_SEGS_DEF,
    parameter int MAX_V_SEGS = MAX_V_SEGS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  t_req       i_req,
    output logic       o_res_valid,
    output t_res       o_res,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  t_cfg_index i_cfg_index,
    input  logic [4:0] i_cfg_data
);
    localparam int MAXSEG = (MAX_U_SEGS > MAX_V_SEGS) ? MAX_U_SEGS : MAX_V_SEGS;
    localparam int SEGW   = $clog2(MAXSEG + 1);
    localparam int UAW    = $clog2(MAX_U_SEGS + 1);
    localparam int VAW    = $clog2(MAX_V_SEGS + 1);
    localparam int CBW    = $clog2(MAX_U_SEGS * MAX_V_SEGS * COORDS);
    localparam int CAW    = CBW + 4;
    localparam int CDEPTH = MAX_U_SEGS * MAX_V_SEGS * COORDS * TERMS;
    localparam int PW     = 66;
    localparam int ACCW   = PW - FRAC_BITS + 5;
    localparam logic [5:0] LAST_TERM = 6'(COORDS * TERMS - 1);
    localparam logic [5:0] NUM_TERMS = 6'(COORDS * TERMS);

    t_state                r_state, n_state;
    logic                  r_dim, n_dim;
    logic [16:0]           r_u, n_u, r_v, n_v;
    logic [4:0]            r_useg, r_vseg;
    logic signed [31:0]    r_b0, n_b0;
    logic signed [32:0]    r_span, n_span;
    logic signed [33:0]    r_x, n_x;
    logic [SEGW-1:0]       r_k, n_k, r_idx, n_idx, r_i, n_i, r_j, n_j;
    logic signed [31:0]    r_w1, n_w1, r_w2, n_w2;
    logic [1:0]            r_wf, n_wf;
    logic signed [31:0]    r_sp [4];
    logic signed [31:0]    n_sp [4];
    logic signed [31:0]    r_tp [4];
    logic signed [31:0]    n_tp [4];
    logic [3:0]            r_sf, n_sf, r_tf, n_tf;
    logic signed [31:0]    r_mono [TERMS];
    logic signed [31:0]    n_mono [TERMS];
    logic [TERMS-1:0]      r_mf, n_mf;
    logic [4:0]            r_mk, n_mk;
    logic [5:0]            r_ci, n_ci, r_t1, n_t1, r_t2, n_t2;
    logic                  r_v1, n_v1, r_v2, n_v2;
    logic signed [ACCW-1:0] r_acc, n_acc;
    logic signed [31:0]    r_pt [COORDS];
    logic signed [31:0]    n_pt [COORDS];
    logic                  r_ovf, n_ovf;
    logic signed [PW-1:0]  r_prod;
    logic signed [32:0]    m_a, m_b;
    t_res                  r_res, n_res;
    logic                  r_res_valid, n_res_valid;

    logic [SEGW-1:0]       nu, nv, nd;
    logic [SEGW-1:0]       br_addr;
    logic [31:0]           u_rd, v_rd, c_rd;
    logic signed [31:0]    br_rd, co;
    logic                  acc_take;
    logic                  u_we, v_we, c_we;
    logic [CAW-1:0]        c_waddr, c_raddr;
    logic [CBW-1:0]        c_base;
    logic [32:0]           s_res, s_res2;
    logic signed [34:0]    d_off;
    logic signed [ACCW-1:0] sum;
    logic [1:0]            ma, mb;
    logic [3:0]            mprev;

    assign acc_take    = i_start && !o_busy;
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // effective segment counts
    always_comb begin
        if (r_useg == 5'd0) begin
            nu = SEGW'(1);
        end else if (int'(r_useg) > MAX_U_SEGS) begin
            nu = SEGW'(MAX_U_SEGS);
        end else begin
            nu = SEGW'(r_useg);
        end
        if (r_vseg == 5'd0) begin
            nv = SEGW'(1);
        end else if (int'(r_vseg) > MAX_V_SEGS) begin
            nv = SEGW'(MAX_V_SEGS);
        end else begin
            nv = SEGW'(r_vseg);
        end
    end
    assign nd    = r_dim ? nv : nu;
    assign br_rd = $signed(r_dim ? v_rd : u_rd);
    assign co    = $signed(c_rd);

    assign u_we = acc_take && (i_req.req_type == REQ_WR_U)
                  && (int'(i_req.break_index) <= MAX_U_SEGS);
    assign v_we = acc_take && (i_req.req_type == REQ_WR_V)
                  && (int'(i_req.break_index) <= MAX_V_SEGS);
    assign c_we = acc_take && (i_req.req_type == REQ_WR_COEF)
                  && (int'(i_req.patch_u) < MAX_U_SEGS)
                  && (int'(i_req.patch_v) < MAX_V_SEGS)
                  && (i_req.coord_sel != COORD_NONE);
    assign c_waddr = {CBW'((CBW'(i_req.patch_u) * CBW'(MAX_V_SEGS) + CBW'(i_req.patch_v))
                           * CBW'(COORDS) + CBW'(i_req.coord_sel)), i_req.term_index};
    assign c_base  = CBW'((CBW'(r_i) * CBW'(MAX_V_SEGS) + CBW'(r_j)) * CBW'(COORDS));
    assign c_raddr = {c_base + CBW'(r_ci[5:4]), r_ci[3:0]};

    bspe_ram #(.WIDTH(32), .DEPTH(MAX_U_SEGS + 1)) u_ubrk (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (UAW'(i_req.break_index)),
        .i_wdata (i_req.load_value),
        .i_raddr (UAW'(br_addr)),
        .o_rdata (u_rd)
    );

    bspe_ram #(.WIDTH(32), .DEPTH(MAX_V_SEGS + 1)) u_vbrk (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (VAW'(i_req.break_index)),
        .i_wdata (i_req.load_value),
        .i_raddr (VAW'(br_addr)),
        .o_rdata (v_rd)
    );

    bspe_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_coef (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (i_req.load_value),
        .i_raddr (c_raddr),
        .o_rdata (c_rd)
    );

    always_comb begin
        n_state     = r_state;
        n_dim       = r_dim;
        n_u         = r_u;
        n_v         = r_v;
        n_b0        = r_b0;
        n_span      = r_span;
        n_x         = r_x;
        n_k         = r_k;
        n_idx       = r_idx;
        n_i         = r_i;
        n_j         = r_j;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_wf        = r_wf;
        n_sp        = r_sp;
        n_tp        = r_tp;
        n_sf        = r_sf;
        n_tf        = r_tf;
        n_mono      = r_mono;
        n_mf        = r_mf;
        n_mk        = r_mk;
        n_ci        = r_ci;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_v1        = 1'b0;
        n_v2        = 1'b0;
        n_acc       = r_acc;
        n_pt        = r_pt;
        n_ovf       = r_ovf;
        n_res       = r_res;
        n_res_valid = 1'b0;
        m_a         = '0;
        m_b         = '0;
        br_addr     = '0;
        s_res       = '0;
        s_res2      = '0;
        d_off       = '0;
        sum         = '0;
        ma          = r_mk[1:0];
        mb          = r_mk[3:2];
        mprev       = 4'(r_mk - 5'd1);

        unique case (r_state)
            S_IDLE: begin
                if (acc_take && i_req.req_type == REQ_EVAL) begin
                    n_u     = (i_req.u_param > PARAM_ONE) ? PARAM_ONE : i_req.u_param;
                    n_v     = (i_req.v_param > PARAM_ONE) ? PARAM_ONE : i_req.v_param;
                    n_dim   = 1'b0;
                    n_ovf   = 1'b0;
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                br_addr = '0;
                n_state = S_RDN;
            end
            S_RDN: begin
                br_addr = nd;
                n_b0    = br_rd;
                n_state = S_SPAN;
            end
            S_SPAN: begin
                n_span  = 33'(br_rd) - 33'(r_b0);
                n_state = S_MUL;
            end
            S_MUL: begin
                m_a     = $signed({16'b0, (r_dim ? r_v : r_u)});
                m_b     = r_span;
                n_state = S_X;
            end
            S_X: begin
                n_x     = 34'(PW'(r_b0) + (r_prod >>> PARAM_BITS));
                br_addr = SEGW'(1);
                n_k     = SEGW'(1);
                n_state = S_SRCH;
            end
            S_SRCH: begin
                // first breakpoint above the scaled value, else the last patch
                if (r_x < 34'(br_rd)) begin
                    n_idx   = r_k - SEGW'(1);
                    br_addr = r_k - SEGW'(1);
                    n_state = S_OFF;
                end else if (r_k == nd) begin
                    n_idx   = nd - SEGW'(1);
                    br_addr = nd - SEGW'(1);
                    n_state = S_OFF;
                end else begin
                    n_k     = r_k + SEGW'(1);
                    br_addr = r_k + SEGW'(1);
                end
            end
            S_OFF: begin
                d_off   = 35'(r_x) - 35'(br_rd);
                s_res   = sat32(SATW'(d_off));
                n_w1    = s_res[31:0];
                n_wf    = {1'b0, s_res[32]};
                n_state = S_P2M;
            end
            S_P2M: begin
                m_a     = 33'(r_w1);
                m_b     = 33'(r_w1);
                n_state = S_P2W;
            end
            S_P2W: begin
                s_res   = sat32(SATW'(r_prod >>> FRAC_BITS));
                n_w2    = s_res[31:0];
                n_wf    = {r_wf[0] | s_res[32], r_wf[0]};
                n_state = S_P3M;
            end
            S_P3M: begin
                m_a     = 33'(r_w2);
                m_b     = 33'(r_w1);
                n_state = S_P3W;
            end
            S_P3W: begin
                s_res = sat32(SATW'(r_prod >>> FRAC_BITS));
                if (!r_dim) begin
                    n_sp[0] = 32'(64'sd1 <<< FRAC_BITS);
                    n_sp[1] = r_w1;
                    n_sp[2] = r_w2;
                    n_sp[3] = s_res[31:0];
                    n_sf    = {r_wf[1] | s_res[32], r_wf[1], r_wf[0], 1'b0};
                    n_i     = r_idx;
                    n_dim   = 1'b1;
                    n_state = S_RD0;
                end else begin
                    n_tp[0] = 32'(64'sd1 <<< FRAC_BITS);
                    n_tp[1] = r_w1;
                    n_tp[2] = r_w2;
                    n_tp[3] = s_res[31:0];
                    n_tf    = {r_wf[1] | s_res[32], r_wf[1], r_wf[0], 1'b0};
                    n_j     = r_idx;
                    n_mk    = '0;
                    n_state = S_MONO;
                end
            end
            S_MONO: begin
                // multiply for term mk while saturating term mk-1
                if (r_mk < 5'd16) begin
                    m_a = 33'(r_sp[ma]);
                    m_b = 33'(r_tp[mb]);
                end
                if (r_mk != 5'd0) begin
                    s_res         = sat32(SATW'(r_prod >>> FRAC_BITS));
                    n_mono[mprev] = s_res[31:0];
                    n_mf[mprev]   = s_res[32] | r_sf[mprev[1:0]] | r_tf[mprev[3:2]];
                end
                if (r_mk == 5'd16) begin
                    n_ci    = '0;
                    n_state = S_ACC;
                end else begin
                    n_mk = r_mk + 5'd1;
                end
            end
            S_ACC: begin
                // read coefficient, multiply, accumulate: three deep
                if (r_ci < NUM_TERMS) begin
                    n_v1 = 1'b1;
                    n_t1 = r_ci;
                    n_ci = r_ci + 6'd1;
                end
                if (r_v1) begin
                    m_a  = 33'(co);
                    m_b  = 33'(r_mono[r_t1[3:0]]);
                    n_v2 = 1'b1;
                    n_t2 = r_t1;
                    if (co != 32'sd0 && r_mf[r_t1[3:0]]) begin
                        n_ovf = 1'b1;
                    end
                end
                if (r_v2) begin
                    sum   = ((r_t2[3:0] == 4'd0) ? ACCW'(0) : r_acc)
                            + ACCW'(r_prod >>> FRAC_BITS);
                    n_acc = sum;
                    if (r_t2[3:0] == 4'd15) begin
                        s_res2            = sat32(SATW'(sum));
                        n_pt[r_t2[5:4]]   = s_res2[31:0];
                        n_ovf             = n_ovf | s_res2[32];
                    end
                    if (r_t2 == LAST_TERM) begin
                        n_res.point_x       = n_pt[0];
                        n_res.point_y       = n_pt[1];
                        n_res.point_z       = n_pt[2];
                        n_res.found_patch_u = 4'(r_i);
                        n_res.found_patch_v = 4'(r_j);
                        n_res.overflow      = n_ovf;
                        n_res_valid         = 1'b1;
                        n_state             = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_useg      <= 5'd1;
            r_vseg      <= 5'd1;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_U_SEGS: r_useg <= i_cfg_data;
                    CFG_V_SEGS: r_vseg <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dim  <= n_dim;
        r_u    <= n_u;
        r_v    <= n_v;
        r_b0   <= n_b0;
        r_span <= n_span;
        r_x    <= n_x;
        r_k    <= n_k;
        r_idx  <= n_idx;
        r_i    <= n_i;
        r_j    <= n_j;
        r_w1   <= n_w1;
        r_w2   <= n_w2;
        r_wf   <= n_wf;
        r_sp   <= n_sp;
        r_tp   <= n_tp;
        r_sf   <= n_sf;
        r_tf   <= n_tf;
        r_mono <= n_mono;
        r_mf   <= n_mf;
        r_mk   <= n_mk;
        r_ci   <= n_ci;
        r_t1   <= n_t1;
        r_t2   <= n_t2;
        r_acc  <= n_acc;
        r_pt   <= n_pt;
        r_ovf  <= n_ovf;
        r_res  <= n_res;
        r_prod <= m_a * m_b;
    end

    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !o_busy)
        else $error("result strobe while sequencer busy");

    a_res_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(r_state == S_ACC))
        else $error("result strobe not preceded by accumulation");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_k != '0 && r_k <= nd))
        else $error("breakpoint search index out of range");

    a_acc_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && r_v2) |-> $past(r_v1))
        else $error("accumulate stage without coefficient read");

endmodule

@@ test/bicubic_spline_patch_evaluator_unit_tb.sv @@
// testbench for bicubic_spline_patch_evaluator_unit: loads breakpoints and patch
// coefficients, evaluates surface points and checks them against a built-in predictor
// depends on bspe_pkg and the evaluator rtl
`timescale 1ns / 100ps

module bicubic_spline_patch_evaluator_unit_tb;
    import bspe_pkg::*;

    localparam int NSEG   = 16;
    localparam int FRAC   = 16;
    localparam int NCOEF  = NSEG * NSEG * COORDS * TERMS;
    localparam int SETTLE = 150;
    localparam int REQW   = $bits(t_req);

    class surface_predictor;
        int    u_brk[NSEG + 1];
        int    v_brk[NSEG + 1];
        int    coef[NCOEF];
        bit    coef_loaded[NCOEF];
        int    u_segs_reg;
        int    v_segs_reg;
        t_res  pending_points[$];
        int    n_points;
        int    n_ovf;
        int    n_writes;
        int    n_mismatch;

        function new();
            u_segs_reg = 1;
            v_segs_reg = 1;
        endfunction

        function int eff_segs(int r);
            if (r == 0) return 1;
            if (r > NSEG) return NSEG;
            return r;
        endfunction

        function longint clamp32(longint v, inout bit hit);
            if (v > 64'sd2147483647) begin
                hit = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                hit = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // scale the parameter onto the span, find its interval, return the local offset
        function longint locate(bit on_v, logic [16:0] par, output int idx);
            int     n;
            longint b0, span, p, x, bk;
            n = on_v ? eff_segs(v_segs_reg) : eff_segs(u_segs_reg);
            b0 = on_v ? v_brk[0] : u_brk[0];
            span = (on_v ? longint'(v_brk[n]) : longint'(u_brk[n])) - b0;
            p = (par > PARAM_ONE) ? 65536 : longint'(par);
            x = b0 + ((p * span) >>> PARAM_BITS);
            idx = n - 1;
            for (int k = 1; k <= n; k++) begin
                bk = on_v ? v_brk[k] : u_brk[k];
                if (x < bk) begin
                    idx = k - 1;
                    break;
                end
            end
            return x - (on_v ? longint'(v_brk[idx]) : longint'(u_brk[idx]));
        endfunction

        function void powers(longint d, output longint pw[4], output bit fl[4]);
            pw[0] = longint'(1) << FRAC;
            fl[0] = 0;
            fl[1] = 0;
            pw[1] = clamp32(d, fl[1]);
            for (int k = 2; k < 4; k++) begin
                fl[k] = fl[k - 1];
                pw[k] = clamp32((pw[k - 1] * pw[1]) >>> FRAC, fl[k]);
            end
        endfunction

        function void set_reg(t_cfg_index idx, logic [4:0] d);
            if (idx == CFG_U_SEGS) u_segs_reg = int'(d);
            else v_segs_reg = int'(d);
        endfunction

        function void note_request(t_req r);
            int     i, j, base;
            longint sp[4], tp[4], mono[TERMS], sum, co;
            bit     sf[4], tf[4], mf[TERMS], ovf;
            t_res   e;
            case (r.req_type)
                REQ_WR_U: begin
                    if (r.break_index <= NSEG) u_brk[r.break_index] = r.load_value;
                    n_writes++;
                end
                REQ_WR_V: begin
                    if (r.break_index <= NSEG) v_brk[r.break_index] = r.load_value;
                    n_writes++;
                end
                REQ_WR_COEF: begin
                    if (r.coord_sel != COORD_NONE) begin
                        base = ((r.patch_u * NSEG + r.patch_v) * COORDS + r.coord_sel) * TERMS
                               + r.term_index;
                        coef[base] = r.load_value;
                        coef_loaded[base] = 1;
                    end
                    n_writes++;
                end
                default: begin
                    powers(locate(0, r.u_param, i), sp, sf);
                    powers(locate(1, r.v_param, j), tp, tf);
                    for (int b = 0; b < 4; b++)
                        for (int a = 0; a < 4; a++) begin
                            mf[a + 4 * b] = sf[a] || tf[b];
                            mono[a + 4 * b] = clamp32((sp[a] * tp[b]) >>> FRAC, mf[a + 4 * b]);
                        end
                    ovf = 0;
                    for (int c = 0; c < COORDS; c++) begin
                        base = ((i * NSEG + j) * COORDS + c) * TERMS;
                        sum = 0;
                        for (int k = 0; k < TERMS; k++) begin
                            co = coef[base + k];
                            if (co != 0 && mf[k]) ovf = 1;
                            sum += (co * mono[k]) >>> FRAC;
                        end
                        sum = clamp32(sum, ovf);
                        if (c == 0) e.point_x = sum[31:0];
                        else if (c == 1) e.point_y = sum[31:0];
                        else e.point_z = sum[31:0];
                    end
                    e.found_patch_u = i[3:0];
                    e.found_patch_v = j[3:0];
                    e.overflow = ovf;
                    if (ovf) n_ovf++;
                    n_points++;
                    pending_points.push_back(e);
                end
            endcase
        endfunction

        function void check_point(t_res got);
            t_res e;
            if (pending_points.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result x=%h y=%h z=%h", got.point_x, got.point_y,
                             got.point_z);
                return;
            end
            e = pending_points.pop_front();
            if (got.point_x !== e.point_x || got.point_y !== e.point_y ||
                got.point_z !== e.point_z || got.found_patch_u !== e.found_patch_u ||
                got.found_patch_v !== e.found_patch_v || got.overflow !== e.overflow) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("mismatch exp x=%h y=%h z=%h pu=%0d pv=%0d ovf=%b", e.point_x,
                             e.point_y, e.point_z, e.found_patch_u, e.found_patch_v, e.overflow);
                    $display("         got x=%h y=%h z=%h pu=%0d pv=%0d ovf=%b", got.point_x,
                             got.point_y, got.point_z, got.found_patch_u, got.found_patch_v,
                             got.overflow);
                end
            end
        endfunction
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_start = 0;
    logic       o_busy;
    t_req       i_req = '0;
    logic       o_res_valid;
    t_res       o_res;
    logic       i_cfg_valid = 0;
    logic       o_cfg_ready;
    t_cfg_index i_cfg_index = CFG_U_SEGS;
    logic [4:0] i_cfg_data = '0;

    surface_predictor sb = new();
    int idle_pct;
    int phase_count;

    bicubic_spline_patch_evaluator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) sb.check_point(o_res);
    end

    task automatic send(t_req r);
        i_start <= 1;
        i_req <= r;
        do @(posedge i_clk); while (o_busy);
        sb.note_request(r);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_start <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $urandom_range(1 << 20) - (1 << 19);
        endcase
    endfunction

    task automatic write_word(t_req_type kind, int bi, int pu, int pv, int cs, int ti,
                              logic [31:0] val);
        t_req r;
        r = t_req'(REQW'({$urandom, $urandom, $urandom}));
        r.req_type = kind;
        r.break_index = 5'(bi);
        r.patch_u = 4'(pu);
        r.patch_v = 4'(pv);
        r.coord_sel = 2'(cs);
        r.term_index = 4'(ti);
        r.load_value = val;
        send(r);
    endtask

    // fill any coefficient of the target patch that has never been loaded, then evaluate
    task automatic evaluate(logic [16:0] u, logic [16:0] v);
        int     pi, pj, base;
        longint dummy;
        t_req   r;
        dummy = sb.locate(0, u, pi);
        dummy = sb.locate(1, v, pj);
        for (int c = 0; c < COORDS; c++)
            for (int k = 0; k < TERMS; k++) begin
                base = ((pi * NSEG + pj) * COORDS + c) * TERMS + k;
                if (!sb.coef_loaded[base]) write_word(REQ_WR_COEF, 0, pi, pj, c, k, rand_coef());
            end
        r = t_req'(REQW'({$urandom, $urandom, $urandom}));
        r.req_type = REQ_EVAL;
        r.u_param = u;
        r.v_param = v;
        send(r);
    endtask

    // style 0 ascending small steps, 1 unordered full range, 2 ascending large steps
    task automatic load_breaks(int style);
        longint pos;
        for (int ax = 0; ax < 2; ax++) begin
            pos = longint'($signed($urandom_range(1 << 22))) - (1 << 21);
            for (int k = 0; k <= NSEG; k++) begin
                write_word(ax ? REQ_WR_V : REQ_WR_U, k, 0, 0, 0, 0,
                           style == 1 ? $urandom : pos[31:0]);
                pos += (style == 2) ? $urandom_range(1 << 26, 1) : $urandom_range(1 << 17, 1);
            end
        end
    endtask

    task automatic write_cfg(t_cfg_index idx, logic [4:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
        i_cfg_valid <= 0;
    endtask

    task automatic drain();
        i_start <= 0;
        while (sb.pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [16:0] rand_param();
        if ($urandom_range(9) == 0) return 17'($urandom_range(131071, 65536));
        return 17'($urandom_range(65536));
    endfunction

    int seg_u[8] = '{1, 16, 0, 31, 3, 16, 2, 7};
    int seg_v[8] = '{1, 16, 31, 0, 5, 1, 16, 4};
    int idle_set[4] = '{0, 64, 0, 38};

    initial begin
        int sel;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        for (int ph = 0; ph < 8; ph++) begin
            idle_pct = idle_set[ph % 4];
            write_cfg(CFG_U_SEGS, 5'(seg_u[ph]));
            write_cfg(CFG_V_SEGS, 5'(seg_v[ph]));
            load_breaks(ph == 5 ? 1 : (ph == 6 ? 2 : 0));
            if (ph == 0) begin
                // corners, parameter above one, extreme coefficients and out-of-range writes that are ignored
                write_word(REQ_WR_COEF, 0, 0, 0, 0, 15, 32'h7fff_ffff);
                write_word(REQ_WR_COEF, 0, 0, 0, 1, 0, 32'h8000_0000);
                write_word(REQ_WR_U, 31, 0, 0, 0, 0, $urandom);
                write_word(REQ_WR_V, 17, 0, 0, 0, 0, $urandom);
                write_word(REQ_WR_COEF, 0, 3, 5, COORD_NONE, 7, $urandom);
                evaluate(0, 0);
                evaluate(17'h10000, 17'h10000);
                evaluate(17'h1ffff, 17'h1ffff);
                evaluate(17'h0ffff, 1);
                evaluate(17'h08000, 17'h10000);
                evaluate(0, 17'h1ffff);
                evaluate(17'h10001, 0);
            end
            for (int n = 0; n < 236; n++) begin
                if (ph == 0 && n == 100) begin
                    i_start <= 0;
                    while (sb.pending_points.size() != 0) @(posedge i_clk);
                end
                sel = $urandom_range(99);
                if (sel < 6)
                    write_word(sel[0] ? REQ_WR_V : REQ_WR_U, $urandom_range(NSEG), 0, 0, 0, 0,
                               $urandom);
                else if (sel < 10)
                    write_word(REQ_WR_U, $urandom_range(31, NSEG + 1), 0, 0, 0, 0, $urandom);
                else if (sel < 13)
                    write_word(REQ_WR_COEF, 0, $urandom_range(15), $urandom_range(15),
                               COORD_NONE, $urandom_range(15), $urandom);
                else if (sel < 17)
                    write_word(REQ_WR_COEF, 0, $urandom_range(15), $urandom_range(15),
                               $urandom_range(2), $urandom_range(15), rand_coef());
                evaluate(rand_param(), rand_param());
            end
            drain();
            phase_count++;
        end
        if (sb.pending_points.size() != 0) sb.n_mismatch += sb.pending_points.size();
        $display("evaluated %0d points (%0d saturating) and %0d store writes over %0d settings",
                 sb.n_points, sb.n_ovf, sb.n_writes, phase_count);
        if (sb.n_mismatch == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", sb.n_mismatch);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bspe_pkg.sv
hw/rtl/bspe_ram.sv
hw/rtl/bicubic_spline_patch_evaluator_unit.sv
test/bicubic_spline_patch_evaluator_unit_tb.sv
